FILE: rtl/tf_pkg.sv
// Shared widths, types and datapath command codes for the tangent frame block.
`timescale 1ns / 1ps
package tf_pkg;

    localparam int POS_W   = 18;
    localparam int TEX_W   = 16;
    localparam int UNIT_W  = 16;
    localparam int UNIT_F  = UNIT_W - 2;

    // stream payload widths, zero filled to whole bytes
    localparam int IN_W    = 3 * POS_W + 2 * TEX_W + 3 * UNIT_W;
    localparam int IN_PAD  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 6 * UNIT_W;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

    localparam int DPOS_W  = POS_W + 1;
    localparam int DTEX_W  = TEX_W + 1;
    localparam int PROD_W  = DPOS_W + DTEX_W;
    localparam int DIR_W   = PROD_W + 1;
    localparam int NRM_A   = (PROD_W + 2 > 2 * UNIT_W + 4) ? PROD_W + 2 : 2 * UNIT_W + 4;
    localparam int NRM_W   = (NRM_A > 32) ? NRM_A : 32;

    // scaled magnitudes sit in [2^29, 2^30)
    localparam int SCL_W   = 30;
    localparam int SQ_W    = 2 * SCL_W + 2;
    localparam int ROOT_W  = SQ_W + 2;
    localparam int ROOT_N  = SQ_W / 2 + 1;
    localparam int LEN_W   = SCL_W + 1;
    localparam int REM_W   = LEN_W + 1;
    localparam int Q_W     = UNIT_F + 2;
    localparam int NUM_W   = SCL_W + UNIT_F + 1;

    localparam int NU_W    = 2 * UNIT_W;
    localparam int DOT_W   = NU_W + 2;
    localparam int D_W     = UNIT_W + 4;
    localparam int ND_W    = UNIT_W + D_W;
    localparam int CR_W    = NU_W + 1;
    localparam int HP_W    = 2 * (SCL_W + 1);
    localparam int HS_W    = HP_W + 2;

    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [TEX_W-1:0]   t_tex;
    typedef logic signed [UNIT_W-1:0]  t_unit;
    typedef logic signed [NRM_W-1:0]   t_nrm;
    typedef logic signed [SCL_W:0]     t_scl;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DELTA,
        OP_TRI_MUL,
        OP_TRI_SUB,
        OP_TRI_FLIP,
        OP_NRM_TD,
        OP_CAP_TD,
        OP_NRM_SD,
        OP_CAP_U,
        OP_ZERO,
        OP_DOT_NU,
        OP_DOT_SUM,
        OP_ROUND_D,
        OP_MUL_ND,
        OP_DIFF,
        OP_NRM_W,
        OP_CAP_TG,
        OP_NRM_C,
        OP_CAP_BT,
        OP_HAND_MUL,
        OP_HAND_SIGN
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] slot;
    } t_dp_cmd;

    typedef struct packed {
        logic nrm_done;
        logic det_zero;
    } t_dp_sts;

endpackage

FILE: rtl/tf_norm.sv
// Multi-cycle vector normalizer: common scaling, integer square root, per-lane divide.
`timescale 1ns / 1ps
module tf_norm import tf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_scale_only,
    input  t_nrm  i_vec [3],
    output logic  o_done,
    output logic  o_nz,
    output t_unit o_q [3],
    output t_scl  o_scl [3]
);

    localparam int CNT_W = $clog2(ROOT_N);

    typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SUM, N_ROOT, N_DSET, N_DIV, N_FIN}
        t_nstate;

    t_nstate                 r_state;
    logic                    r_done;
    logic                    r_nz;
    logic                    r_scale_only;
    logic [NRM_W-1:0]        r_m [3];
    logic                    r_sgn [3];
    logic [2*SCL_W-1:0]      r_sq [3];
    logic [ROOT_W-1:0]       r_x;
    logic [ROOT_W-1:0]       r_r;
    logic [ROOT_W-1:0]       r_bit;
    logic [CNT_W-1:0]        r_cnt;
    logic [LEN_W-1:0]        r_len;
    logic [REM_W-1:0]        r_rem [3];
    logic [Q_W-1:0]          r_low [3];
    logic [Q_W-1:0]          r_quo [3];
    t_unit                   r_q [3];

    logic [NRM_W-1:0]        m_or;
    logic [NRM_W-1:0]        n_mag [3];
    logic [ROOT_W-1:0]       root_t;
    logic [NUM_W-1:0]        num [3];
    logic [REM_W-1:0]        div_t [3];
    logic [Q_W-1:0]          q_cap [3];

    always_comb begin
        m_or   = r_m[0] | r_m[1] | r_m[2];
        root_t = r_r + r_bit;
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_vec[i][NRM_W-1] ? NRM_W'(-i_vec[i]) : NRM_W'(i_vec[i]);
            num[i]   = {r_m[i][SCL_W-1:0], UNIT_F'(0)} + NUM_W'(r_r[LEN_W-1:1]);
            div_t[i] = {r_rem[i][REM_W-2:0], r_low[i][Q_W-1]};
            q_cap[i] = (r_quo[i] > Q_W'(1 << UNIT_F)) ? Q_W'(1 << UNIT_F) : r_quo[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_scale_only <= i_scale_only;
                        for (int i = 0; i < 3; i++) begin
                            r_m[i]   <= n_mag[i];
                            r_sgn[i] <= i_vec[i][NRM_W-1];
                            r_q[i]   <= '0;
                        end
                        if ((n_mag[0] | n_mag[1] | n_mag[2]) == '0) begin
                            r_nz   <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_nz    <= 1'b1;
                            r_state <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    if (|m_or[NRM_W-1:SCL_W]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (!m_or[SCL_W-1]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else if (r_scale_only) begin
                        r_done  <= 1'b1;
                        r_state <= N_IDLE;
                    end else begin
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_sq[i] <= (2*SCL_W)'(r_m[i][SCL_W-1:0]) *
                                   (2*SCL_W)'(r_m[i][SCL_W-1:0]);
                    end
                    r_state <= N_SUM;
                end
                N_SUM: begin
                    r_x     <= ROOT_W'(r_sq[0]) + ROOT_W'(r_sq[1]) + ROOT_W'(r_sq[2]);
                    r_r     <= '0;
                    r_bit   <= ROOT_W'(1) << SQ_W;
                    r_cnt   <= '0;
                    r_state <= N_ROOT;
                end
                N_ROOT: begin
                    if (r_x >= root_t) begin
                        r_x <= r_x - root_t;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ROOT_N - 1)) r_state <= N_DSET;
                end
                N_DSET: begin
                    r_len <= r_r[LEN_W-1:0];
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= REM_W'(num[i][NUM_W-1:Q_W]);
                        r_low[i] <= num[i][Q_W-1:0];
                        r_quo[i] <= '0;
                    end
                    r_cnt   <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        if (div_t[i] >= REM_W'(r_len)) begin
                            r_rem[i] <= div_t[i] - REM_W'(r_len);
                            r_quo[i] <= {r_quo[i][Q_W-2:0], 1'b1};
                        end else begin
                            r_rem[i] <= div_t[i];
                            r_quo[i] <= {r_quo[i][Q_W-2:0], 1'b0};
                        end
                        r_low[i] <= r_low[i] << 1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(Q_W - 1)) r_state <= N_FIN;
                end
                N_FIN: begin
                    for (int i = 0; i < 3; i++) begin
                        r_q[i] <= r_sgn[i] ? -UNIT_W'(q_cap[i]) : UNIT_W'(q_cap[i]);
                    end
                    r_done  <= 1'b1;
                    r_state <= N_IDLE;
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_nz   = r_nz;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_q[i]   = r_q[i];
            o_scl[i] = r_sgn[i] ? -(SCL_W+1)'(r_m[i][SCL_W-1:0])
                                : (SCL_W+1)'(r_m[i][SCL_W-1:0]);
        end
    end

endmodule

FILE: rtl/tf_datapath.sv
// Datapath: held corners, triangle directions, per-corner frame arithmetic.
`timescale 1ns / 1ps
module tf_datapath import tf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    input  t_pos    i_pos [3],
    input  t_tex    i_tex [2],
    input  t_unit   i_nrm [3],
    output t_unit   o_tan [3],
    output t_unit   o_bitan [3],
    output logic    o_degen
);

    t_pos                      r_hp [3][3];
    t_tex                      r_ht [3][2];
    t_unit                     r_hn [3][3];
    logic signed [DPOS_W-1:0]  r_e1 [3];
    logic signed [DPOS_W-1:0]  r_e2 [3];
    logic signed [DTEX_W-1:0]  r_s1, r_t1, r_s2, r_t2;
    logic signed [PROD_W-1:0]  r_pa [3];
    logic signed [PROD_W-1:0]  r_pb [3];
    logic signed [PROD_W-1:0]  r_pc [3];
    logic signed [PROD_W-1:0]  r_pd [3];
    logic signed [PROD_W-1:0]  r_q0, r_q1;
    logic signed [DIR_W-1:0]   r_sd [3];
    logic signed [DIR_W-1:0]   r_td [3];
    logic signed [DIR_W-1:0]   r_det;
    logic                      r_det_zero;
    t_scl                      r_mt [3];
    logic                      r_td_nz;
    t_unit                     r_u [3];
    logic signed [NU_W-1:0]    r_nu [3];
    logic signed [DOT_W-1:0]   r_dot;
    logic signed [D_W-1:0]     r_d;
    logic signed [ND_W-1:0]    r_nd [3];
    logic signed [NU_W-1:0]    r_ca [3];
    logic signed [NU_W-1:0]    r_cb [3];
    t_nrm                      r_w [3];
    logic signed [CR_W-1:0]    r_c [3];
    t_unit                     r_tg [3];
    t_unit                     r_bt [3];
    t_scl                      r_mc [3];
    logic                      r_c_nz;
    logic signed [HP_W-1:0]    r_hprod [3];

    t_unit                     nv [3];
    logic [DOT_W-1:0]          dot_mag;
    logic [DOT_W-1:0]          dot_rnd;
    logic signed [HS_W-1:0]    hand_sum;
    logic                      nrm_start;
    logic                      nrm_done;
    logic                      nrm_nz;
    t_nrm                      nrm_vec [3];
    t_unit                     nrm_q [3];
    t_scl                      nrm_scl [3];

    always_comb begin
        for (int i = 0; i < 3; i++) nv[i] = r_hn[i_cmd.slot][i];
        dot_mag  = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : DOT_W'(r_dot);
        dot_rnd  = (dot_mag + DOT_W'(1 << (UNIT_F - 1))) >> UNIT_F;
        hand_sum = HS_W'(r_hprod[0]) + HS_W'(r_hprod[1]) + HS_W'(r_hprod[2]);
        nrm_start = (i_cmd.op == OP_NRM_TD) || (i_cmd.op == OP_NRM_SD) ||
                    (i_cmd.op == OP_NRM_W)  || (i_cmd.op == OP_NRM_C);
        for (int i = 0; i < 3; i++) begin
            unique case (i_cmd.op)
                OP_NRM_TD: nrm_vec[i] = NRM_W'(r_td[i]);
                OP_NRM_SD: nrm_vec[i] = NRM_W'(r_sd[i]);
                OP_NRM_W:  nrm_vec[i] = r_w[i];
                default:   nrm_vec[i] = NRM_W'(r_c[i]);
            endcase
        end
    end

    tf_norm u_norm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (nrm_start),
        .i_scale_only (i_cmd.op == OP_NRM_TD),
        .i_vec        (nrm_vec),
        .o_done       (nrm_done),
        .o_nz         (nrm_nz),
        .o_q          (nrm_q),
        .o_scl        (nrm_scl)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_hp[i_cmd.slot][i] <= i_pos[i];
                    r_hn[i_cmd.slot][i] <= i_nrm[i];
                end
                r_ht[i_cmd.slot][0] <= i_tex[0];
                r_ht[i_cmd.slot][1] <= i_tex[1];
            end
            OP_DELTA: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= DPOS_W'(r_hp[1][i]) - DPOS_W'(r_hp[0][i]);
                    r_e2[i] <= DPOS_W'(r_hp[2][i]) - DPOS_W'(r_hp[0][i]);
                end
                r_s1 <= DTEX_W'(r_ht[1][0]) - DTEX_W'(r_ht[0][0]);
                r_t1 <= DTEX_W'(r_ht[1][1]) - DTEX_W'(r_ht[0][1]);
                r_s2 <= DTEX_W'(r_ht[2][0]) - DTEX_W'(r_ht[0][0]);
                r_t2 <= DTEX_W'(r_ht[2][1]) - DTEX_W'(r_ht[0][1]);
            end
            OP_TRI_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    r_pa[i] <= PROD_W'(r_t2) * PROD_W'(r_e1[i]);
                    r_pb[i] <= PROD_W'(r_t1) * PROD_W'(r_e2[i]);
                    r_pc[i] <= PROD_W'(r_s1) * PROD_W'(r_e2[i]);
                    r_pd[i] <= PROD_W'(r_s2) * PROD_W'(r_e1[i]);
                end
                r_q0 <= PROD_W'(r_s1) * PROD_W'(r_t2);
                r_q1 <= PROD_W'(r_s2) * PROD_W'(r_t1);
            end
            OP_TRI_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    r_sd[i] <= DIR_W'(r_pa[i]) - DIR_W'(r_pb[i]);
                    r_td[i] <= DIR_W'(r_pc[i]) - DIR_W'(r_pd[i]);
                end
                r_det <= DIR_W'(r_q0) - DIR_W'(r_q1);
            end
            OP_TRI_FLIP: begin
                if (r_det[DIR_W-1]) begin
                    for (int i = 0; i < 3; i++) begin
                        r_sd[i] <= -r_sd[i];
                        r_td[i] <= -r_td[i];
                    end
                end
                r_det_zero <= (r_det == '0);
            end
            OP_CAP_TD: begin
                for (int i = 0; i < 3; i++) r_mt[i] <= nrm_scl[i];
                r_td_nz <= nrm_nz;
            end
            OP_CAP_U: begin
                for (int i = 0; i < 3; i++) r_u[i] <= nrm_q[i];
            end
            OP_ZERO: begin
                for (int i = 0; i < 3; i++) begin
                    r_tg[i] <= '0;
                    r_bt[i] <= '0;
                end
            end
            OP_DOT_NU: begin
                for (int i = 0; i < 3; i++) r_nu[i] <= NU_W'(nv[i]) * NU_W'(r_u[i]);
            end
            OP_DOT_SUM: begin
                r_dot <= DOT_W'(r_nu[0]) + DOT_W'(r_nu[1]) + DOT_W'(r_nu[2]);
            end
            OP_ROUND_D: begin
                r_d <= r_dot[DOT_W-1] ? -D_W'(dot_rnd) : D_W'(dot_rnd);
            end
            OP_MUL_ND: begin
                for (int i = 0; i < 3; i++) r_nd[i] <= ND_W'(nv[i]) * ND_W'(r_d);
                r_ca[0] <= NU_W'(nv[1]) * NU_W'(r_u[2]);
                r_cb[0] <= NU_W'(nv[2]) * NU_W'(r_u[1]);
                r_ca[1] <= NU_W'(nv[2]) * NU_W'(r_u[0]);
                r_cb[1] <= NU_W'(nv[0]) * NU_W'(r_u[2]);
                r_ca[2] <= NU_W'(nv[0]) * NU_W'(r_u[1]);
                r_cb[2] <= NU_W'(nv[1]) * NU_W'(r_u[0]);
            end
            OP_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_w[i] <= (NRM_W'(r_u[i]) <<< UNIT_F) - NRM_W'(r_nd[i]);
                    r_c[i] <= CR_W'(r_ca[i]) - CR_W'(r_cb[i]);
                end
            end
            OP_CAP_TG: begin
                for (int i = 0; i < 3; i++) r_tg[i] <= nrm_q[i];
            end
            OP_CAP_BT: begin
                for (int i = 0; i < 3; i++) begin
                    r_bt[i] <= nrm_q[i];
                    r_mc[i] <= nrm_scl[i];
                end
                r_c_nz <= nrm_nz;
            end
            OP_HAND_MUL: begin
                for (int i = 0; i < 3; i++) r_hprod[i] <= HP_W'(r_mc[i]) * HP_W'(r_mt[i]);
            end
            OP_HAND_SIGN: begin
                // flip the bitangent when it points against the t direction
                if (r_c_nz && r_td_nz && hand_sum[HS_W-1]) begin
                    for (int i = 0; i < 3; i++) r_bt[i] <= -r_bt[i];
                end
            end
            default: ;
        endcase
    end

    assign o_sts.nrm_done = nrm_done;
    assign o_sts.det_zero = r_det_zero;
    assign o_degen        = r_det_zero;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_tan[i]   = r_tg[i];
            o_bitan[i] = r_bt[i];
        end
    end

endmodule

FILE: rtl/tf_ctrl.sv
// Controller: corner counting, operation sequencing and result handshake.
`timescale 1ns / 1ps
module tf_ctrl import tf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output logic    o_out_last,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE, S_DELTA, S_TMUL, S_TSUB, S_TFLIP,
        S_NTD, S_WTD, S_CTD, S_NSD, S_WSD, S_CSD,
        S_KCHK, S_NU, S_DSUM, S_RND, S_ND, S_DIFF,
        S_NW, S_WW, S_CW, S_NC, S_WC, S_CC, S_HM, S_HS, S_OUT
    } t_state;

    t_state     r_state;
    logic [1:0] r_cnt;
    logic [1:0] r_k;
    logic       r_valid;
    logic       r_last;
    logic       accept;

    assign accept = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        o_cmd.slot = (r_state == S_IDLE) ? r_cnt : r_k;
        unique case (r_state)
            S_IDLE:  o_cmd.op = accept ? OP_LOAD : OP_NONE;
            S_DELTA: o_cmd.op = OP_DELTA;
            S_TMUL:  o_cmd.op = OP_TRI_MUL;
            S_TSUB:  o_cmd.op = OP_TRI_SUB;
            S_TFLIP: o_cmd.op = OP_TRI_FLIP;
            S_NTD:   o_cmd.op = OP_NRM_TD;
            S_CTD:   o_cmd.op = OP_CAP_TD;
            S_NSD:   o_cmd.op = OP_NRM_SD;
            S_CSD:   o_cmd.op = OP_CAP_U;
            S_KCHK:  o_cmd.op = i_sts.det_zero ? OP_ZERO : OP_NONE;
            S_NU:    o_cmd.op = OP_DOT_NU;
            S_DSUM:  o_cmd.op = OP_DOT_SUM;
            S_RND:   o_cmd.op = OP_ROUND_D;
            S_ND:    o_cmd.op = OP_MUL_ND;
            S_DIFF:  o_cmd.op = OP_DIFF;
            S_NW:    o_cmd.op = OP_NRM_W;
            S_CW:    o_cmd.op = OP_CAP_TG;
            S_NC:    o_cmd.op = OP_NRM_C;
            S_CC:    o_cmd.op = OP_CAP_BT;
            S_HM:    o_cmd.op = OP_HAND_MUL;
            S_HS:    o_cmd.op = OP_HAND_SIGN;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_cnt == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= S_DELTA;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_DELTA: r_state <= S_TMUL;
                S_TMUL:  r_state <= S_TSUB;
                S_TSUB:  r_state <= S_TFLIP;
                S_TFLIP: r_state <= S_NTD;
                S_NTD:   r_state <= S_WTD;
                S_WTD:   if (i_sts.nrm_done) r_state <= S_CTD;
                S_CTD:   r_state <= S_NSD;
                S_NSD:   r_state <= S_WSD;
                S_WSD:   if (i_sts.nrm_done) r_state <= S_CSD;
                S_CSD: begin
                    r_k     <= '0;
                    r_state <= S_KCHK;
                end
                S_KCHK: begin
                    if (i_sts.det_zero) begin
                        r_valid <= 1'b1;
                        r_last  <= (r_k == 2'd2);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_NU;
                    end
                end
                S_NU:    r_state <= S_DSUM;
                S_DSUM:  r_state <= S_RND;
                S_RND:   r_state <= S_ND;
                S_ND:    r_state <= S_DIFF;
                S_DIFF:  r_state <= S_NW;
                S_NW:    r_state <= S_WW;
                S_WW:    if (i_sts.nrm_done) r_state <= S_CW;
                S_CW:    r_state <= S_NC;
                S_NC:    r_state <= S_WC;
                S_WC:    if (i_sts.nrm_done) r_state <= S_CC;
                S_CC:    r_state <= S_HM;
                S_HM:    r_state <= S_HS;
                S_HS: begin
                    r_valid <= 1'b1;
                    r_last  <= (r_k == 2'd2);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_valid <= 1'b0;
                        if (r_k == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_KCHK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;
    assign o_out_last  = r_last;

endmodule

FILE: rtl/triangle_tangent_frame.sv
// Top level of the per-corner tangent frame block for unindexed triangles.
//
//   channel  | direction | payload (lowest bits first)                    | side info
//   s_axis   | in        | pos_x pos_y pos_z tex_u tex_v norm_x y z       | -
//   m_axis   | out       | tan_x tan_y tan_z bitan_x bitan_y bitan_z      | tuser=degenerate, tlast
//
// The first two corners of a triangle are taken and only held.
// The third corner starts the triangle run: deltas and directions, then the
// shared normalizer in full calls (shift loop, 32-step square root, 16-step
// divide) and in a scale-only pass on the t direction; two calls per triangle
// plus two per corner, and the corner calls are skipped when the determinant is zero.
// Synchronous active-low reset returns to waiting for the first corner.
// While a result is held on m_axis, the block stalls and accepts no request.
`timescale 1ns / 1ps
module triangle_tangent_frame import tf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z, zero fill
    input  logic [IN_PAD-1:0]     s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z
    output logic [OUT_PAD-1:0]    m_axis_tdata,
    // degenerate
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int TEX_LO  = 3 * POS_W;
    localparam int NRM_LO  = TEX_LO + 2 * TEX_W;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_pos    in_pos [3];
    t_tex    in_tex [2];
    t_unit   in_nrm [3];
    t_unit   out_tan [3];
    t_unit   out_bitan [3];
    logic    out_degen;

    // unpack the request fields
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_pos[i] = s_axis_tdata[i*POS_W +: POS_W];
            in_nrm[i] = s_axis_tdata[NRM_LO + i*UNIT_W +: UNIT_W];
        end
        for (int i = 0; i < 2; i++) in_tex[i] = s_axis_tdata[TEX_LO + i*TEX_W +: TEX_W];
    end

    tf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    tf_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .i_pos   (in_pos),
        .i_tex   (in_tex),
        .i_nrm   (in_nrm),
        .o_tan   (out_tan),
        .o_bitan (out_bitan),
        .o_degen (out_degen)
    );

    // pack the result; the frame registers hold while the result waits
    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            m_axis_tdata[i*UNIT_W +: UNIT_W]       = out_tan[i];
            m_axis_tdata[(3+i)*UNIT_W +: UNIT_W]   = out_bitan[i];
        end
    end
    assign m_axis_tuser = out_degen;

    // one item at a time: never take a request while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request accepted while a result is pending");

    // the last result of a triangle frees the input side right away
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("input not ready after last corner result");

    // a degenerate triangle gives zero vectors
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate result carries nonzero vectors");

endmodule

FILE: tb/tb_triangle_tangent_frame.sv
// Self-checking bench for triangle_tangent_frame: random and directed corners, scoreboard.
`timescale 1ns / 1ps
module tb_triangle_tangent_frame;
    import tf_pkg::*;

    localparam int IN_BITS   = 3 * POS_W + 2 * TEX_W + 3 * UNIT_W;
    localparam int IN_PAD_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W = ((6 * UNIT_W + 7) / 8) * 8;
    localparam int N_RANDOM_TRI = 66;
    localparam int QUIET_ITEMS  = 40;
    localparam int STALL_LIMIT  = 8000;
    localparam int TAIL_CYCLES  = 60;

    typedef struct {
        logic [IN_PAD_W-1:0] data;
        bit                  drain;
    } corner_req_t;

    typedef struct {
        logic [OUT_PAD_W-1:0] frame;
        logic                 degen;
        logic                 last;
    } frame_res_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_PAD_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_PAD_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    triangle_tangent_frame dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    corner_req_t corner_q[$];
    frame_res_t  frame_expect_q[$];
    int          total_corners;
    int          sent_corners;
    int          err_count;

    // tangent frame predictor state
    longint held_pos[2][3];
    longint held_tex[2][2];
    longint held_nrm[2][3];
    int     corners_held;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint unsigned mag_of(longint a);
        return (a < 0) ? longint'(-a) : longint'(a);
    endfunction

    // bring the largest magnitude into [2^29, 2^30) with one common shift
    function automatic bit scale_vec(input longint a[3], output longint unsigned m[3]);
        longint unsigned mx;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag_of(a[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 1'b0;
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        return 1'b1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_vec(input longint a[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned len, q, one;
        one = 64'd1 << UNIT_F;
        if (!scale_vec(a, m)) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << UNIT_F) + len / 2) / len;
            if (q > one) q = one;
            o[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint round_away(longint a, int sh);
        longint unsigned m;
        m = (mag_of(a) + (64'd1 << (sh - 1))) >> sh;
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    // take one accepted corner; on the third, queue three expected frames
    function automatic void predict_frames(logic [IN_PAD_W-1:0] d);
        t_pos   px, py, pz;
        t_tex   tu, tv;
        t_unit  nx, ny, nz;
        longint p[3], n[3][3], e1[3], e2[3], sd[3], td[3], u[3], w[3], c[3];
        longint tg[3], bt[3], tc[2];
        longint s1, s2, t1, t2, det, dn, dot, a, b;
        longint unsigned mc[3], mt[3];
        frame_res_t r;
        {nz, ny, nx, tv, tu, pz, py, px} = d[IN_BITS-1:0];
        p[0] = longint'(px); p[1] = longint'(py); p[2] = longint'(pz);
        tc[0] = longint'(tu); tc[1] = longint'(tv);
        n[2][0] = longint'(nx); n[2][1] = longint'(ny); n[2][2] = longint'(nz);
        if (corners_held < 2) begin
            for (int i = 0; i < 3; i++) begin
                held_pos[corners_held][i] = p[i];
                held_nrm[corners_held][i] = n[2][i];
            end
            held_tex[corners_held][0] = tc[0];
            held_tex[corners_held][1] = tc[1];
            corners_held++;
            return;
        end
        corners_held = 0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = held_pos[1][i] - held_pos[0][i];
            e2[i] = p[i] - held_pos[0][i];
            n[0][i] = held_nrm[0][i];
            n[1][i] = held_nrm[1][i];
        end
        s1 = held_tex[1][0] - held_tex[0][0];
        t1 = held_tex[1][1] - held_tex[0][1];
        s2 = tc[0] - held_tex[0][0];
        t2 = tc[1] - held_tex[0][1];
        det = s1 * t2 - s2 * t1;
        for (int i = 0; i < 3; i++) begin
            sd[i] = t2 * e1[i] - t1 * e2[i];
            td[i] = s1 * e2[i] - s2 * e1[i];
            if (det < 0) begin
                sd[i] = -sd[i];
                td[i] = -td[i];
            end
        end
        unit_vec(sd, u);
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                tg[i] = 0;
                bt[i] = 0;
            end
            if (det != 0) begin
                dn = n[k][0] * u[0] + n[k][1] * u[1] + n[k][2] * u[2];
                dn = round_away(dn, UNIT_F);
                for (int i = 0; i < 3; i++) w[i] = u[i] * (longint'(1) << UNIT_F) - n[k][i] * dn;
                unit_vec(w, tg);
                c[0] = n[k][1] * u[2] - n[k][2] * u[1];
                c[1] = n[k][2] * u[0] - n[k][0] * u[2];
                c[2] = n[k][0] * u[1] - n[k][1] * u[0];
                unit_vec(c, bt);
                // flip the bitangent where it points against the t direction
                if (scale_vec(c, mc) && scale_vec(td, mt)) begin
                    dot = 0;
                    for (int i = 0; i < 3; i++) begin
                        a = (c[i] < 0) ? -longint'(mc[i]) : longint'(mc[i]);
                        b = (td[i] < 0) ? -longint'(mt[i]) : longint'(mt[i]);
                        dot += a * b;
                    end
                    if (dot < 0) for (int i = 0; i < 3; i++) bt[i] = -bt[i];
                end
            end
            r.frame = '0;
            for (int i = 0; i < 3; i++) begin
                r.frame[i*UNIT_W +: UNIT_W]     = tg[i][UNIT_W-1:0];
                r.frame[(3+i)*UNIT_W +: UNIT_W] = bt[i][UNIT_W-1:0];
            end
            r.degen = (det == 0);
            r.last  = (k == 2);
            frame_expect_q.push_back(r);
        end
    endfunction

    task automatic add_corner(input longint x, y, z, u, v, nx, ny, nz, input bit drain = 0);
        corner_req_t c;
        t_pos  px, py, pz;
        t_tex  tu, tv;
        t_unit qx, qy, qz;
        px = t_pos'(x); py = t_pos'(y); pz = t_pos'(z);
        tu = t_tex'(u); tv = t_tex'(v);
        qx = t_unit'(nx); qy = t_unit'(ny); qz = t_unit'(nz);
        c.data  = '0;
        c.data[IN_BITS-1:0] = {qz, qy, qx, tv, tu, pz, py, px};
        c.drain = drain;
        corner_q.push_back(c);
    endtask

    function automatic longint rnd_pos(bit tiny);
        if (tiny) return longint'($urandom_range(0, 4096)) - 2048;
        return longint'($urandom_range(0, 262143)) - 131072;
    endfunction

    function automatic longint rnd_tex();
        return longint'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic longint rnd_norm();
        if ($urandom_range(0, 9) == 0) return longint'($urandom_range(0, 65535)) - 32768;
        return longint'($urandom_range(0, 32768)) - 16384;
    endfunction

    // driver: hold the request until taken, then advance or idle
    int  src_gap;
    bit  src_wait_drain;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_frames(s_axis_tdata);
                sent_corners++;
            end
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (corner_q.size() > 0 && corner_q[0].drain
                         && frame_expect_q.size() > 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (corner_q.size() > 0) begin
                s_axis_tdata  <= corner_q[0].data;
                s_axis_tvalid <= 1'b1;
                void'(corner_q.pop_front());
                if (sent_corners < total_corners - QUIET_ITEMS && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 6);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each taken result with the oldest expectation
    int sink_gap;
    always @(posedge i_clk) begin
        frame_res_t x;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap      = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_expect_q.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h", $time, m_axis_tdata);
                    err_count++;
                end else begin
                    x = frame_expect_q.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (m_axis_tdata[i*UNIT_W +: UNIT_W] !== x.frame[i*UNIT_W +: UNIT_W]) begin
                            $display("%0t: component %0d expected %h actual %h", $time, i,
                                     x.frame[i*UNIT_W +: UNIT_W],
                                     m_axis_tdata[i*UNIT_W +: UNIT_W]);
                            err_count++;
                        end
                    if (m_axis_tuser !== x.degen) begin
                        $display("%0t: degenerate expected %b actual %b", $time, x.degen,
                                 m_axis_tuser);
                        err_count++;
                    end
                    if (m_axis_tlast !== x.last) begin
                        $display("%0t: last expected %b actual %b", $time, x.last,
                                 m_axis_tlast);
                        err_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (sent_corners < total_corners - QUIET_ITEMS && $urandom_range(0, 3) == 0)
                    sink_gap = $urandom_range(1, 6);
            end
        end
    end

    // watchdog: count cycles with no handshake on either side
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        bit tiny;
        longint tu, tv;
        i_rst_n       = 1'b0;

        // extremes of the position and texcoord fields
        add_corner(-131072, -131072, -131072, -32768, -32768, 16384, 0, 0);
        add_corner(131071, 131071, -131072, 32767, -32768, 0, -16384, 0);
        add_corner(131071, -131072, 131071, -32768, 32767, 0, 0, 16384);
        // zero texture determinant: all texcoords equal
        add_corner(100, 200, 300, 5000, -7000, 0, 16384, 0);
        add_corner(900, -200, 30, 5000, -7000, 0, 16384, 0);
        add_corner(-100, 250, 700, 5000, -7000, 0, 16384, 0);
        // zero s direction with nonzero determinant: coincident corners
        add_corner(512, 512, 512, 0, 0, 0, 0, 16384);
        add_corner(512, 512, 512, 16384, 0, 0, 0, 16384);
        add_corner(512, 512, 512, 0, 16384, 0, 0, 16384);
        // normal parallel to the s direction
        add_corner(0, 0, 0, 0, 0, 16384, 0, 0);
        add_corner(256, 0, 0, 16384, 0, 16384, 0, 0);
        add_corner(0, 256, 0, 0, 16384, -16384, 0, 0);
        // normals outside the unit range, used at their width
        add_corner(0, 0, 0, 0, 0, -32768, 32767, -32768);
        add_corner(1000, 20, -5, 300, 40, 32767, -32768, 32767);
        add_corner(-30, 700, 9, -20, 900, 0, 0, 0);

        for (int t = 0; t < N_RANDOM_TRI; t++) begin
            tiny = ($urandom_range(0, 2) == 0);
            tu = rnd_tex();
            tv = rnd_tex();
            for (int k = 0; k < 3; k++)
                // now and then repeat the texcoord for a flat mapping
                if ($urandom_range(0, 11) == 0)
                    add_corner(rnd_pos(tiny), rnd_pos(tiny), rnd_pos(tiny), tu, tv,
                               rnd_norm(), rnd_norm(), rnd_norm(),
                               t == N_RANDOM_TRI / 2 && k == 0);
                else
                    add_corner(rnd_pos(tiny), rnd_pos(tiny), rnd_pos(tiny), rnd_tex(),
                               rnd_tex(), rnd_norm(), rnd_norm(), rnd_norm(),
                               t == N_RANDOM_TRI / 2 && k == 0);
        end
        total_corners = corner_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (corner_q.size() == 0 && !s_axis_tvalid);
        wait (frame_expect_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && frame_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
